@@ hw/rtl/q2e_pkg.sv @@
`timescale 1ns / 1ps
// Package for the quaternion to Euler angle pipeline.
// Holds datapath widths, angle constants, the arctangent table and the square-root latency.
package q2e_pkg;

  localparam int QW          = 16;   // quaternion component width, Q2.14
  localparam int TW          = 34;   // width of the ZYX sine/cosine terms, Q28
  localparam int PW          = 29;   // pitch argument width when not clamped
  localparam int AW          = 16;   // roll/yaw output width, Q3.13
  localparam int PAW         = 15;   // pitch output width, Q2.13
  localparam int XW          = 37;   // CORDIC vector width
  localparam int ZW          = 35;   // CORDIC angle accumulator width, Q30

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 24;

  // Floor square root of a value up to 2^56: one result bit per stage.
  localparam int SQRT_BITS   = 29;
  // Square, subtract from one, then one stage per root bit.
  localparam int SQRT_LAT    = SQRT_BITS + 2;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [TW-1:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [17:0]   PI_Q13      = 18'sd25736;
  localparam logic signed [17:0]   HALF_PI_Q13 = 18'sd12868;

  // atan(2^-i), truncated to Q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/q2e_delay.sv @@
`timescale 1ns / 1ps
// Enabled shift line that keeps side data aligned with the pipeline.
// Depends on nothing.
module q2e_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) tap_r[k] <= tap_r[k-1];
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule

@@ hw/rtl/q2e_terms.sv @@
`timescale 1ns / 1ps
// Two stages: quaternion component products, then the ZYX sine/cosine terms.
// Depends on q2e_pkg.
module q2e_terms import q2e_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_i,
  input  logic signed [QW-1:0]  w_i,
  input  logic signed [QW-1:0]  x_i,
  input  logic signed [QW-1:0]  y_i,
  input  logic signed [QW-1:0]  z_i,
  output logic                  valid_o,
  output logic signed [TW-1:0]  sinr_o,
  output logic signed [TW-1:0]  cosr_o,
  output logic signed [TW-1:0]  siny_o,
  output logic signed [TW-1:0]  cosy_o,
  output logic signed [PW-1:0]  sinp_o,
  output logic                  sat_o,
  output logic                  sat_neg_o
);

  logic                 v1_r, v2_r;
  logic signed [31:0]   wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  logic signed [TW-1:0] sinr_r, cosr_r, siny_r, cosy_r;
  logic signed [PW-1:0] sinp_r;
  logic                 sat_r, sat_neg_r;

  logic signed [32:0]   s_r_sum, s_y_sum, c_r_sum, c_y_sum, p_diff;
  logic signed [TW-1:0] sinp_full, sinr_nxt, cosr_nxt, siny_nxt, cosy_nxt;
  logic                 sat_pos, sat_neg;

  always_comb begin
    s_r_sum   = {wx_r[31], wx_r} + {yz_r[31], yz_r};
    s_y_sum   = {wz_r[31], wz_r} + {xy_r[31], xy_r};
    c_r_sum   = {xx_r[31], xx_r} + {yy_r[31], yy_r};
    c_y_sum   = {yy_r[31], yy_r} + {zz_r[31], zz_r};
    p_diff    = {wy_r[31], wy_r} - {zx_r[31], zx_r};
    sinr_nxt  = {s_r_sum, 1'b0};
    siny_nxt  = {s_y_sum, 1'b0};
    cosr_nxt  = ONE_Q28 - {c_r_sum, 1'b0};
    cosy_nxt  = ONE_Q28 - {c_y_sum, 1'b0};
    sinp_full = {p_diff, 1'b0};
    sat_pos   = sinp_full >= ONE_Q28;
    sat_neg   = sinp_full <= -ONE_Q28;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r      <= w_i * x_i;
      yz_r      <= y_i * z_i;
      xx_r      <= x_i * x_i;
      yy_r      <= y_i * y_i;
      wz_r      <= w_i * z_i;
      xy_r      <= x_i * y_i;
      zz_r      <= z_i * z_i;
      wy_r      <= w_i * y_i;
      zx_r      <= z_i * x_i;
      sinr_r    <= sinr_nxt;
      cosr_r    <= cosr_nxt;
      siny_r    <= siny_nxt;
      cosy_r    <= cosy_nxt;
      sat_r     <= sat_pos | sat_neg;
      sat_neg_r <= sat_neg;
      // clamped arguments skip the root: feed zero
      sinp_r    <= (sat_pos | sat_neg) ? '0 : sinp_full[PW-1:0];
    end
  end

  assign valid_o   = v2_r;
  assign sinr_o    = sinr_r;
  assign cosr_o    = cosr_r;
  assign siny_o    = siny_r;
  assign cosy_o    = cosy_r;
  assign sinp_o    = sinp_r;
  assign sat_o     = sat_r;
  assign sat_neg_o = sat_neg_r;

endmodule

@@ hw/rtl/q2e_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined cosine of pitch: floor(sqrt(2^56 - s*s)), one root bit per stage.
// Depends on q2e_pkg.
module q2e_isqrt import q2e_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [PW-1:0] s_i,
  output logic                 valid_o,
  output logic signed [PW-1:0] s_o,
  output logic [PW-1:0]        c_o
);

  localparam int NW = 57;
  localparam int RW = 58;

  logic                 va_r;
  logic signed [PW-1:0] sa_r;
  logic [NW-1:0]        sq_r;
  logic signed [2*PW-1:0] prod;

  logic                 v_r [SQRT_BITS+1];
  logic signed [PW-1:0] s_r [SQRT_BITS+1];
  logic [NW-1:0]        n_r [SQRT_BITS+1];
  logic [RW-1:0]        r_r [SQRT_BITS+1];

  assign prod = s_i * s_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= prod[NW-1:0];
      sa_r   <= s_i;
      n_r[0] <= (NW'(1) << 56) - sq_r;
      r_r[0] <= '0;
      s_r[0] <= sa_r;
    end
  end

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_root
    localparam logic [RW-1:0] BIT = RW'(1) << (56 - 2*k);
    logic [RW-1:0] trial;
    logic          take;
    assign trial = r_r[k] + BIT;
    assign take  = {1'b0, n_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1] <= s_r[k];
        if (take) begin
          n_r[k+1] <= n_r[k] - trial[NW-1:0];
          r_r[k+1] <= (r_r[k] >> 1) + BIT;
        end else begin
          n_r[k+1] <= n_r[k];
          r_r[k+1] <= r_r[k] >> 1;
        end
      end
    end
  end

  assign valid_o = v_r[SQRT_BITS];
  assign s_o     = s_r[SQRT_BITS];
  assign c_o     = r_r[SQRT_BITS][PW-1:0];

endmodule

@@ hw/rtl/q2e_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined four-quadrant CORDIC atan2, one micro-rotation per stage.
// Depends on q2e_pkg; result is Q13 rounded half up and clamped to +-pi.
module q2e_cordic import q2e_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic signed [TW-1:0] y_i,
  input  logic signed [TW-1:0] x_i,
  output logic                 valid_o,
  output logic signed [AW-1:0] angle_o
);

  localparam int NS = (STEPS < CORDIC_MAX) ? STEPS : CORDIC_MAX;

  logic                 v_r    [NS+1];
  logic                 zero_r [NS+1];
  logic signed [XW-1:0] x_r    [NS+1];
  logic signed [XW-1:0] y_r    [NS+1];
  logic signed [ZW-1:0] z_r    [NS+1];

  logic                 vo_r;
  logic signed [AW-1:0] ang_r;

  logic signed [XW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0, zr;
  logic signed [17:0]   zq;
  logic signed [AW-1:0] ang_nxt;

  // Fold the left half-plane onto the right and seed with +-pi.
  always_comb begin
    xe = {{(XW-TW){x_i[TW-1]}}, x_i};
    ye = {{(XW-TW){y_i[TW-1]}}, y_i};
    if (x_i[TW-1]) begin
      x0 = -xe;
      y0 = -ye;
      z0 = y_i[TW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x0 = xe;
      y0 = ye;
      z0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = $signed({3'b000, atan_q30(i)});
    logic signed [XW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ATAN;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ATAN;
        end
      end
    end
  end

  // Q30 to Q13: add half, floor shift, clamp.
  always_comb begin
    zr = z_r[NS] + ZW'(65536);
    zq = zr[ZW-1:17];
    if (zero_r[NS])         ang_nxt = '0;
    else if (zq > PI_Q13)   ang_nxt = PI_Q13[AW-1:0];
    else if (zq < -PI_Q13)  ang_nxt = AW'(-PI_Q13);
    else                    ang_nxt = zq[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) ang_r <= ang_nxt;
  end

  assign valid_o = vo_r;
  assign angle_o = ang_r;

endmodule

@@ hw/rtl/quaternion_to_euler_angles.sv @@
`timescale 1ns / 1ps
// Quaternion (w, x, y, z, signed Q2.14) to ZYX Euler angles roll, pitch and yaw
// in signed radians, Q3.13 for roll and yaw and Q2.13 for pitch. The block is a
// fully pipelined datapath that takes a transfer every cycle unless stalled and
// returns one result per input. Two stages form the products and the sine/cosine
// terms, 31 stages build the pitch cosine with a bit-per-stage square root,
// CORDIC_STEPS + 2 stages (steps capped at CORDIC_MAX) run the atan2 rotations,
// and one output register holds the result. Roll and yaw run their own CORDIC in
// parallel and wait in a delay line for pitch. A stall on a waiting result freezes
// the whole pipeline; nothing is lost or repeated. When |2(wy - zx)| reaches one,
// pitch holds at +-pi/2 with the argument's sign and out_pitch_saturated is set.
// Depends on q2e_pkg, q2e_terms, q2e_isqrt, q2e_cordic, q2e_delay.
module quaternion_to_euler_angles import q2e_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [QW-1:0]  in_quat_w,
  input  logic signed [QW-1:0]  in_quat_x,
  input  logic signed [QW-1:0]  in_quat_y,
  input  logic signed [QW-1:0]  in_quat_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [AW-1:0]  out_roll_angle,
  output logic signed [PAW-1:0] out_pitch_angle,
  output logic signed [AW-1:0]  out_yaw_angle,
  output logic                  out_pitch_saturated
);

  localparam int NS       = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;
  localparam int CORD_LAT = NS + 2;

  logic en;

  logic                 t_vld, t_sat, t_sat_neg;
  logic signed [TW-1:0] t_sinr, t_cosr, t_siny, t_cosy;
  logic signed [PW-1:0] t_sinp;

  logic                 s_vld;
  logic signed [PW-1:0] s_s;
  logic [PW-1:0]        s_c;

  logic                 p_vld, r_vld, y_vld;
  logic signed [AW-1:0] p_ang, roll_ang, yaw_ang;
  logic [2*AW-1:0]      ry_late;
  logic [1:0]           sat_late;

  logic                  out_valid_r, sat_r;
  logic signed [AW-1:0]  roll_r, yaw_r;
  logic signed [PAW-1:0] pitch_r, pitch_nxt;

  // Advance everything unless a result is waiting on a stalled receiver.
  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  q2e_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (in_valid),
    .w_i       (in_quat_w),
    .x_i       (in_quat_x),
    .y_i       (in_quat_y),
    .z_i       (in_quat_z),
    .valid_o   (t_vld),
    .sinr_o    (t_sinr),
    .cosr_o    (t_cosr),
    .siny_o    (t_siny),
    .cosy_o    (t_cosy),
    .sinp_o    (t_sinp),
    .sat_o     (t_sat),
    .sat_neg_o (t_sat_neg)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (t_vld),
    .y_i     (t_sinr),
    .x_i     (t_cosr),
    .valid_o (r_vld),
    .angle_o (roll_ang)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (t_vld),
    .y_i     (t_siny),
    .x_i     (t_cosy),
    .valid_o (y_vld),
    .angle_o (yaw_ang)
  );

  q2e_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (t_vld),
    .s_i     (t_sinp),
    .valid_o (s_vld),
    .s_o     (s_s),
    .c_o     (s_c)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (s_vld),
    .y_i     ({{(TW-PW){s_s[PW-1]}}, s_s}),
    .x_i     ({{(TW-PW){1'b0}}, s_c}),
    .valid_o (p_vld),
    .angle_o (p_ang)
  );

  // Hold roll/yaw for the square-root stages.
  q2e_delay #(.W(2*AW), .DEPTH(SQRT_LAT)) u_ry_dly (
    .clk (clk),
    .en  (en),
    .d_i ({roll_ang, yaw_ang}),
    .q_o (ry_late)
  );

  // Carry the clamp decision alongside the whole pitch path.
  q2e_delay #(.W(2), .DEPTH(SQRT_LAT + CORD_LAT)) u_sat_dly (
    .clk (clk),
    .en  (en),
    .d_i ({t_sat, t_sat_neg}),
    .q_o (sat_late)
  );

  // Pitch: clamp to +-pi/2, or force it when the argument reached one.
  always_comb begin
    if (sat_late[1]) begin
      pitch_nxt = sat_late[0] ? PAW'(-HALF_PI_Q13) : HALF_PI_Q13[PAW-1:0];
    end else if (p_ang > AW'(HALF_PI_Q13)) begin
      pitch_nxt = HALF_PI_Q13[PAW-1:0];
    end else if (p_ang < AW'(-HALF_PI_Q13)) begin
      pitch_nxt = PAW'(-HALF_PI_Q13);
    end else begin
      pitch_nxt = p_ang[PAW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= ry_late[2*AW-1:AW];
      yaw_r   <= ry_late[AW-1:0];
      pitch_r <= pitch_nxt;
      sat_r   <= sat_late[1];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_roll_angle      = roll_r;
  assign out_yaw_angle       = yaw_r;
  assign out_pitch_angle     = pitch_r;
  assign out_pitch_saturated = sat_r;

  a_sat_pitch : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sat_r |->
      (pitch_r == HALF_PI_Q13[PAW-1:0]) || (pitch_r == PAW'(-HALF_PI_Q13)))
    else $error("saturated pitch is not +-pi/2");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (pitch_r <= PAW'(HALF_PI_Q13)) && (pitch_r >= PAW'(-HALF_PI_Q13)))
    else $error("pitch out of range");

  a_roll_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (roll_r <= AW'(PI_Q13)) && (roll_r >= AW'(-PI_Q13))
                 && (yaw_r <= AW'(PI_Q13)) && (yaw_r >= AW'(-PI_Q13)))
    else $error("roll or yaw out of range");

  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(pitch_r) && $stable(roll_r) && out_valid_r)
    else $error("pipeline moved while stalled");

  a_path_align : assert property (@(posedge clk) disable iff (!rst_n)
    r_vld == y_vld)
    else $error("roll and yaw paths out of step");

endmodule
